[hw/rtl/swhsr_pkg.sv]
// Shared types and constants for the single-wire humidity sensor reader.
// Used by the interfaces, the register file, the protocol core and the top level.
`default_nettype none

package swhsr_pkg;

  localparam int TimeWidth = 16;
  localparam int CfgTimeWidth = 16;
  localparam int CmpWidth = (TimeWidth > CfgTimeWidth) ? TimeWidth : CfgTimeWidth;
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth = 16;

  localparam logic [TimeWidth-1:0] TimeMax = {TimeWidth{1'b1}};

  typedef enum logic [CfgIndexWidth-1:0] {
    RegStartLowTime       = 3'd0,
    RegReleaseHighTime    = 3'd1,
    RegResponseCheckTime  = 3'd2,
    RegResponseConfirmTime = 3'd3,
    RegPostResponseTime   = 3'd4,
    RegBitSampleDelay     = 3'd5,
    RegBytesPerReading    = 3'd6,
    RegWaitLowMode        = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    StatusNone = 2'd0,
    StatusGood = 2'd1,
    StatusBad  = 2'd2
  } status_e;

  typedef enum logic [8:0] {
    PhIdle         = 9'b000000001,
    PhStartLow     = 9'b000000010,
    PhReleaseHigh  = 9'b000000100,
    PhCheck        = 9'b000001000,
    PhConfirm      = 9'b000010000,
    PhPost         = 9'b000100000,
    PhBitHigh      = 9'b001000000,
    PhBitDelay     = 9'b010000000,
    PhBitLow       = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic [15:0] start_low_time;
    logic [7:0]  release_high_time;
    logic [7:0]  response_check_time;
    logic [7:0]  response_confirm_time;
    logic [7:0]  post_response_time;
    logic [7:0]  bit_sample_delay;
    logic [3:0]  bytes_per_reading;
    logic        wait_low_mode;
  } cfg_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       response_valid;
    logic [1:0] response_status;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       busy_res;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/swhsr_if.sv]
// Handshake interfaces for the input, result and configuration channels.
// Depends on swhsr_pkg for the configuration index and data widths.
`default_nettype none

interface swhsr_in_if;
  logic valid;
  logic ready;
  logic func;
  logic line_level;

  modport source (output valid, output func, output line_level, input ready);
  modport sink (input valid, input func, input line_level, output ready);
endinterface

interface swhsr_out_if;
  logic       valid;
  logic       ready;
  logic       drive_enable;
  logic       drive_level;
  logic       response_valid;
  logic [1:0] response_status;
  logic       byte_valid;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       busy_res;

  modport source (output valid, output drive_enable, output drive_level,
                  output response_valid, output response_status, output byte_valid,
                  output data_byte, output last_byte, output busy_res, input ready);
  modport sink (input valid, input drive_enable, input drive_level,
                input response_valid, input response_status, input byte_valid,
                input data_byte, input last_byte, input busy_res, output ready);
endinterface

interface swhsr_cfg_if
  import swhsr_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [CfgIndexWidth-1:0] index;
  logic [CfgDataWidth-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/single_wire_humidity_sensor_reader.sv]
// Single-wire humidity sensor reader.
// The input channel carries either a one-microsecond tick with the sampled
// data line or a start command; each transaction yields exactly one result
// transaction with the line drive, response status, byte and busy fields.
// Configuration is written through its own channel, which is always ready;
// write it only while no transaction is in flight.
// An accepted transaction is held in an input register; the protocol core
// steps once when the output register is empty or being taken, and the
// result is loaded into the output register.
// Throughput is one transaction per cycle while the receiver takes results,
// set by the step of the state machine between the two registers.
// When the receiver stalls, the result holds, the input register keeps one
// more transaction, and input ready drops once both are occupied.
// Reset empties both registers, returns the core to idle and loads the
// default timing configuration.
// Depends on swhsr_pkg, swhsr_if, swhsr_cfg and swhsr_core.
`default_nettype none

module single_wire_humidity_sensor_reader
  import swhsr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  swhsr_in_if.sink     in_i,
  swhsr_out_if.source  out_o,
  swhsr_cfg_if.sink    cfg_i
);

  cfg_t    cfg;
  result_t res;

  logic    in_valid_d, in_valid_q;
  logic    in_func_q, in_line_q;
  logic    out_valid_d, out_valid_q;
  result_t out_q;
  logic    step;

  assign step = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  assign in_valid_d = (in_i.valid && in_i.ready) ? 1'b1 : (step ? 1'b0 : in_valid_q);
  assign out_valid_d = step ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  swhsr_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  swhsr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .func_i       (in_func_q),
    .line_level_i (in_line_q),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_func_q <= in_i.func;
      in_line_q <= in_i.line_level;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.drive_enable = out_q.drive_enable;
  assign out_o.drive_level = out_q.drive_level;
  assign out_o.response_valid = out_q.response_valid;
  assign out_o.response_status = out_q.response_status;
  assign out_o.byte_valid = out_q.byte_valid;
  assign out_o.data_byte = out_q.data_byte;
  assign out_o.last_byte = out_q.last_byte;
  assign out_o.busy_res = out_q.busy_res;

endmodule

`default_nettype wire

[hw/rtl/swhsr_cfg.sv]
// Configuration register file of the sensor reader.
// Depends on swhsr_pkg and the configuration interface in swhsr_if.
`default_nettype none

module swhsr_cfg
  import swhsr_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  swhsr_cfg_if.sink   cfg_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_d, cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.index))
        RegStartLowTime:        cfg_d.start_low_time = cfg_i.data;
        RegReleaseHighTime:     cfg_d.release_high_time = cfg_i.data[7:0];
        RegResponseCheckTime:   cfg_d.response_check_time = cfg_i.data[7:0];
        RegResponseConfirmTime: cfg_d.response_confirm_time = cfg_i.data[7:0];
        RegPostResponseTime:    cfg_d.post_response_time = cfg_i.data[7:0];
        RegBitSampleDelay:      cfg_d.bit_sample_delay = cfg_i.data[7:0];
        RegBytesPerReading:     cfg_d.bytes_per_reading = cfg_i.data[3:0];
        RegWaitLowMode:         cfg_d.wait_low_mode = cfg_i.data[0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_low_time        <= 16'd18000;
      cfg_q.release_high_time     <= 8'd24;
      cfg_q.response_check_time   <= 8'd40;
      cfg_q.response_confirm_time <= 8'd80;
      cfg_q.post_response_time    <= 8'd60;
      cfg_q.bit_sample_delay      <= 8'd40;
      cfg_q.bytes_per_reading     <= 4'd5;
      cfg_q.wait_low_mode         <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/swhsr_core.sv]
// Protocol state machine of the sensor reader: one step per tick or start command.
// Depends on swhsr_pkg for the phase encoding, configuration and result types.
`default_nettype none

module swhsr_core
  import swhsr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  wire logic func_i,
  input  wire logic line_level_i,
  input  wire cfg_t cfg_i,
  output result_t   res_o
);

  phase_e               phase_d, phase_q;
  logic [TimeWidth-1:0] tick_d, tick_q;
  logic [2:0]           bit_d, bit_q;
  logic [3:0]           bytes_d, bytes_q;
  logic [7:0]           shift_d, shift_q;
  logic                 good_d, good_q;

  logic [TimeWidth-1:0] tick_inc;
  logic                 tick_sat;

  assign tick_inc = (tick_q == TimeMax) ? tick_q : tick_q + 1'b1;
  assign tick_sat = (tick_inc == TimeMax);

  function automatic logic wait_hit(logic [TimeWidth-1:0] elapsed,
                                    logic [CfgTimeWidth-1:0] limit, logic sat);
    return (CmpWidth'(elapsed) >= CmpWidth'(limit)) || sat;
  endfunction

  always_comb begin
    logic post_done;
    post_done = 1'b0;
    phase_d = phase_q;
    tick_d = tick_q;
    bit_d = bit_q;
    bytes_d = bytes_q;
    shift_d = shift_q;
    good_d = good_q;
    res_o = '0;

    if (func_i) begin
      phase_d = PhStartLow;
      tick_d = '0;
      bit_d = '0;
      bytes_d = '0;
      shift_d = '0;
      good_d = 1'b0;
    end else begin
      unique case (phase_q)
        PhIdle: begin
        end
        PhStartLow: begin
          tick_d = tick_inc;
          if (wait_hit(tick_inc, cfg_i.start_low_time, tick_sat)) begin
            phase_d = PhReleaseHigh;
            tick_d = '0;
          end
        end
        PhReleaseHigh: begin
          tick_d = tick_inc;
          if (wait_hit(tick_inc, CfgTimeWidth'(cfg_i.release_high_time), tick_sat)) begin
            phase_d = PhCheck;
            tick_d = '0;
          end
        end
        PhCheck: begin
          tick_d = tick_inc;
          if (wait_hit(tick_inc, CfgTimeWidth'(cfg_i.response_check_time), tick_sat)) begin
            tick_d = '0;
            if (!line_level_i) begin
              phase_d = PhConfirm;
            end else begin
              res_o.response_valid = 1'b1;
              res_o.response_status = StatusNone;
              good_d = 1'b0;
              phase_d = PhPost;
            end
          end
        end
        PhConfirm: begin
          tick_d = tick_inc;
          if (wait_hit(tick_inc, CfgTimeWidth'(cfg_i.response_confirm_time), tick_sat)) begin
            tick_d = '0;
            res_o.response_valid = 1'b1;
            good_d = line_level_i;
            res_o.response_status = line_level_i ? StatusGood : StatusBad;
            phase_d = PhPost;
          end
        end
        PhPost: begin
          if (cfg_i.wait_low_mode) begin
            post_done = !line_level_i;
          end else begin
            tick_d = tick_inc;
            post_done = wait_hit(tick_inc, CfgTimeWidth'(cfg_i.post_response_time), tick_sat);
          end
          if (post_done) begin
            tick_d = '0;
            if (good_q) begin
              bit_d = '0;
              bytes_d = '0;
              shift_d = '0;
              phase_d = PhBitHigh;
            end else begin
              phase_d = PhIdle;
            end
          end
        end
        PhBitHigh: begin
          if (line_level_i) begin
            phase_d = PhBitDelay;
            tick_d = '0;
          end
        end
        PhBitDelay: begin
          tick_d = tick_inc;
          if (wait_hit(tick_inc, CfgTimeWidth'(cfg_i.bit_sample_delay), tick_sat)) begin
            shift_d = {shift_q[6:0], line_level_i};
            phase_d = PhBitLow;
            tick_d = '0;
          end
        end
        PhBitLow: begin
          if (!line_level_i) begin
            tick_d = '0;
            bit_d = bit_q + 1'b1;
            phase_d = PhBitHigh;
            if (bit_q == 3'd7) begin
              res_o.byte_valid = 1'b1;
              res_o.data_byte = shift_q;
              bytes_d = bytes_q + 1'b1;
              if (bytes_d == 4'd0 || bytes_d >= cfg_i.bytes_per_reading) begin
                res_o.last_byte = 1'b1;
                phase_d = PhIdle;
              end else begin
                shift_d = '0;
              end
            end
          end
        end
        default: phase_d = PhIdle;
      endcase
    end

    res_o.drive_enable = (phase_d == PhStartLow) || (phase_d == PhReleaseHigh);
    res_o.drive_level = (phase_d == PhReleaseHigh);
    res_o.busy_res = (phase_d != PhIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      tick_q <= '0;
      bit_q <= '0;
      bytes_q <= '0;
      shift_q <= '0;
      good_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q <= tick_d;
      bit_q <= bit_d;
      bytes_q <= bytes_d;
      shift_q <= shift_d;
      good_q <= good_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/swhsr_checker.sv]
// Port-level checks for the sensor reader, attached to the top level by bind.
// Depends only on the top level's ports; no package types are needed.
`default_nettype none

module swhsr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       drive_enable_i,
  input wire logic       drive_level_i,
  input wire logic       response_valid_i,
  input wire logic       byte_valid_i,
  input wire logic [7:0] data_byte_i,
  input wire logic       last_byte_i,
  input wire logic       busy_res_i
);

  // A stalled result transaction stays valid and keeps its byte, busy and drive-enable fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(data_byte_i)
      && $stable(busy_res_i) && $stable(drive_enable_i))
    else $error("result transaction changed while stalled");

  // A driven high level only occurs while the line is driven during a reading.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && drive_level_i |-> drive_enable_i && busy_res_i)
    else $error("drive level without drive enable or busy");

  // A completed byte never shares a tick with the response decision or with line drive.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && byte_valid_i |-> !response_valid_i && !drive_enable_i)
    else $error("byte reported during response or start phase");

  // The final byte ends the reading.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_byte_i |-> byte_valid_i && !busy_res_i)
    else $error("last byte without byte or with reading still busy");

endmodule

bind single_wire_humidity_sensor_reader swhsr_checker u_swhsr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .drive_enable_i   (out_o.drive_enable),
  .drive_level_i    (out_o.drive_level),
  .response_valid_i (out_o.response_valid),
  .byte_valid_i     (out_o.byte_valid),
  .data_byte_i      (out_o.data_byte),
  .last_byte_i      (out_o.last_byte),
  .busy_res_i       (out_o.busy_res)
);

`default_nettype wire
